>>> sv/chct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the convex hull cull test block.
// No dependencies; imported by chct_mac and convex_hull_cull_test.
package chct_pkg;

  localparam int MAX_PLANES_DEF = 16;
  localparam int CFG_W          = 5;
  localparam int MASK_W         = 16;
  localparam int MASK_IW        = 4;
  localparam int NRM_W          = 16;
  localparam int POS_W          = 32;
  localparam int PROD_W         = NRM_W + POS_W;
  localparam int ACC_W          = 51;
  localparam int FRAC_SHIFT     = 14;

  // offset term enters the dot product as d * -2^14
  localparam logic signed [NRM_W-1:0] NEG_SCALE = -16'sd16384;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_BOX    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAC,
    ST_DRAIN,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [3:0]              plane_index;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic [MASK_W-1:0]       plane_mask;
  } in_word_t;

  typedef struct packed {
    logic              outside;
    logic [MASK_W-1:0] mask_out;
  } out_word_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic signed [POS_W-1:0] offset;
  } plane_t;

  localparam int PLANE_W = $bits(plane_t);

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

endpackage

>>> sv/chct_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/chct_mac.sv
`timescale 1ns / 1ps
// Shared 16x32 signed multiply-accumulate unit: registered product, then accumulator.
// Depends on chct_pkg.
module chct_mac import chct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [NRM_W-1:0] a,
  input  logic signed [POS_W-1:0] b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 ctl_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d <= '0;
    end else begin
      ctl_d <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
    if (ctl_d.en) begin
      acc <= (ctl_d.clr ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
  end

endmodule

>>> sv/convex_hull_cull_test.sv
`timescale 1ns / 1ps
// Convex hull cull test top level: plane store, sequencer and shared MAC.
// Depends on chct_pkg, chct_ram and chct_mac.
//
// Keeps up to MAX_PLANES planes (normal Q1.14, offset Q23.8) and tests spheres
// and boxes against the planes enabled by the word's mask, lowest index first.
// All distances come from one 16x32 multiplier used four times per distance
// (three normal terms and the offset); a sphere needs one distance per enabled
// plane and a box up to two, and each disabled plane below plane_count is skipped
// in the scan state. A test stops at the first plane it lies fully outside. A
// load word is taken while idle and written straight into the plane store.
// Input is taken while a previous result still waits at the output.
// plane_count is written only while the block is idle.
module convex_hull_cull_test import chct_pkg::*; #(
  parameter int MAX_PLANES = MAX_PLANES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int IW = $clog2(MAX_PLANES + 1);

  state_t                  state, state_next;
  logic [CFG_W-1:0]        plane_count;
  logic [CFG_W-1:0]        n_full;
  logic [IW-1:0]           n_act;
  logic [IW-1:0]           idx;
  logic [MASK_IW-1:0]      bit_sel;
  logic [1:0]              step;
  logic                    pass;
  logic                    is_box;
  logic signed [POS_W-1:0] pa [3];
  logic signed [POS_W-1:0] pb [3];
  logic [MASK_W-1:0]       orig_mask;
  logic [MASK_W-1:0]       mask_r;
  logic [MASK_W-1:0]       outm;
  logic                    res_outside;
  logic [MASK_W-1:0]       res_mask;

  logic                    in_acc;
  logic                    load_we;
  plane_t                  load_word;
  logic                    ram_re;
  logic [PLANE_W-1:0]      ram_rdata;
  plane_t                  plane;
  mac_ctl_t                mac_ctl;
  logic signed [NRM_W-1:0] mac_a;
  logic signed [POS_W-1:0] mac_b;
  logic signed [ACC_W-1:0] plane_dist;
  logic signed [ACC_W-1:0] r_ext;
  logic                    scan_end;
  logic                    hit_out;
  logic                    slot_free;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  assign n_full  = (plane_count > CFG_W'(MAX_PLANES)) ? CFG_W'(MAX_PLANES) : plane_count;
  assign n_act   = IW'(n_full);
  assign bit_sel = MASK_IW'(idx);

  // plane store
  assign load_we = in_acc && (in_data.mode == MODE_LOAD) &&
                   ({1'b0, in_data.plane_index} < CFG_W'(MAX_PLANES));
  assign load_word.nx     = in_data.first_x[NRM_W-1:0];
  assign load_word.ny     = in_data.first_y[NRM_W-1:0];
  assign load_word.nz     = in_data.first_z[NRM_W-1:0];
  assign load_word.offset = in_data.second_x;

  chct_ram #(
    .WIDTH (PLANE_W),
    .DEPTH (MAX_PLANES)
  ) u_planes (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(in_data.plane_index)),
    .wdata (load_word),
    .re    (ram_re),
    .raddr (AW'(idx)),
    .rdata (ram_rdata)
  );

  assign plane = plane_t'(ram_rdata);

  // operand select: sphere uses the center; box pass 0 the negative vertex,
  // pass 1 the positive vertex
  function automatic logic signed [POS_W-1:0] vtx(input logic nneg, input logic box,
                                                  input logic p1,
                                                  input logic signed [POS_W-1:0] lo,
                                                  input logic signed [POS_W-1:0] hi);
    logic use_hi;
    begin
      use_hi = box && (nneg ? p1 : !p1);
      return use_hi ? hi : lo;
    end
  endfunction

  always_comb begin
    case (step)
      2'd0: begin
        mac_a = plane.nx;
        mac_b = vtx(!plane.nx[NRM_W-1], is_box, pass, pa[0], pb[0]);
      end
      2'd1: begin
        mac_a = plane.ny;
        mac_b = vtx(!plane.ny[NRM_W-1], is_box, pass, pa[1], pb[1]);
      end
      2'd2: begin
        mac_a = plane.nz;
        mac_b = vtx(!plane.nz[NRM_W-1], is_box, pass, pa[2], pb[2]);
      end
      default: begin
        mac_a = NEG_SCALE;
        mac_b = plane.offset;
      end
    endcase
  end

  chct_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (plane_dist)
  );

  assign r_ext    = ACC_W'(pb[0]) <<< FRAC_SHIFT;
  assign scan_end = (idx >= n_act);
  assign hit_out  = is_box ? (!pass && (plane_dist >= 0)) : (plane_dist > r_ext);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_re     = 1'b0;
    mac_ctl    = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_data.mode == MODE_SPHERE || in_data.mode == MODE_BOX)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end else if (orig_mask[bit_sel]) begin
          ram_re     = 1'b1;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (step == 2'd0);
        if (step == 2'd3) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit_out) begin
          state_next = ST_DONE;
        end else if (is_box && !pass) begin
          state_next = ST_MAC;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        plane_count <= cfg_data;
      end
      if (state == ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx       <= '0;
        step      <= '0;
        pass      <= 1'b0;
        is_box    <= (in_data.mode == MODE_BOX);
        pa[0]     <= in_data.first_x;
        pa[1]     <= in_data.first_y;
        pa[2]     <= in_data.first_z;
        pb[0]     <= in_data.second_x;
        pb[1]     <= in_data.second_y;
        pb[2]     <= in_data.second_z;
        orig_mask <= in_data.plane_mask;
        mask_r    <= in_data.plane_mask;
        outm      <= '0;
      end
      ST_SCAN: begin
        if (scan_end) begin
          res_outside <= 1'b0;
          res_mask    <= is_box ? outm : mask_r;
        end else if (!orig_mask[bit_sel]) begin
          idx <= idx + IW'(1);
        end
      end
      ST_MAC: begin
        step <= step + 2'd1;
      end
      ST_CHECK: begin
        if (hit_out) begin
          res_outside <= 1'b1;
          res_mask    <= is_box ? orig_mask : mask_r;
        end else if (is_box && !pass) begin
          pass <= 1'b1;
        end else begin
          pass <= 1'b0;
          idx  <= idx + IW'(1);
          if (!is_box && (plane_dist < -r_ext)) begin
            mask_r[bit_sel] <= 1'b0;
          end
          if (is_box && (plane_dist > 0)) begin
            outm[bit_sel] <= 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_data.outside  <= res_outside;
          out_data.mask_out <= res_mask;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_test_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_data.mode == MODE_SPHERE || in_data.mode == MODE_BOX) |=> state == ST_SCAN)
    else $error("test word did not start a scan");

  a_mac_four_terms: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAC && step == 2'd3 |=> state == ST_DRAIN)
    else $error("distance sequence did not end after four terms");

  a_drain_after_mac: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> $past(state) == ST_MAC)
    else $error("accumulator drain without a distance sequence");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && slot_free |=> out_valid && state == ST_IDLE)
    else $error("finished result not posted");

endmodule
